// ===== rtl/ge3_pkg.sv =====
package ge3_pkg;

	localparam int DEF_MAX_COLUMNS = 1024;
	localparam int DEF_MAX_ROWS = 1024;

	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(64);
	localparam logic [CFG_W-1:0] CFG_SIZE_MIN = CFG_W'(3);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ROW_FIRST,
		ROW_SECOND,
		ROW_LATER
	} ge3_row_t;

	typedef struct packed {
		logic tile_walkable;
		logic padding;
	} ge3_in_t;

	typedef struct packed {
		logic nav_walkable;
		logic last_tile;
	} ge3_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0] value;
	} ge3_cfg_t;

	// one column of the 3x3 window plus what the front decided about the result
	typedef struct packed {
		logic [2:0] vec;
		logic due;
		logic interior;
		logic last;
	} ge3_cls_t;

endpackage

// ===== rtl/ge3_chan_if.sv =====
interface ge3_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ge3_front.sv =====
module ge3_front #(
	parameter int MAX_COLUMNS = ge3_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = ge3_pkg::DEF_MAX_ROWS
) (
	input logic clk,
	input logic arst_n,
	input logic [$clog2(MAX_COLUMNS)-1:0] col_last,
	input logic [$clog2(MAX_ROWS)-1:0] row_last,
	input logic restart,
	ge3_chan_if.sink tiles,
	output logic cls_valid,
	input logic cls_ready,
	output ge3_pkg::ge3_cls_t cls_data
);
	import ge3_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [CW-1:0] col_q;
	ge3_row_t row_q;
	ge3_row_t row_nxt;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;

	logic accept;
	logic due;
	logic interior;
	logic last;

	// {upper, lower} line store entry per column
	logic [1:0] store_q [MAX_COLUMNS];
	logic store_wr;

	logic valid_s1;
	logic [1:0] rd_s1;
	logic bit_s1;
	logic [CW-1:0] col_s1;
	logic due_s1;
	logic interior_s1;
	logic last_s1;

	assign tiles.ready = !valid_s1 || cls_ready;
	assign accept = tiles.valid && tiles.ready;
	assign store_wr = valid_s1 && cls_ready;

	assign due = (row_q == ROW_LATER) || (row_q == ROW_SECOND && col_q != '0);
	assign interior = (orow_q != '0) && (orow_q != row_last)
		&& (ocol_q != '0) && (ocol_q != col_last);
	assign last = (orow_q == row_last) && (ocol_q == col_last);

	always_comb begin
		case (row_q)
			ROW_FIRST: row_nxt = ROW_SECOND;
			ROW_SECOND: row_nxt = ROW_LATER;
			default: row_nxt = ROW_LATER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= ROW_FIRST;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= ROW_FIRST;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (due && last) begin
				// grid done: next beat starts a new grid
				col_q <= '0;
				row_q <= ROW_FIRST;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (col_q == col_last) begin
					col_q <= '0;
					row_q <= row_nxt;
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (due) begin
					if (ocol_q == col_last) begin
						ocol_q <= '0;
						orow_q <= orow_q + RW'(1);
					end else begin
						ocol_q <= ocol_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tiles.ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_s1 <= tiles.data.tile_walkable && !tiles.data.padding;
			col_s1 <= col_q;
			due_s1 <= due;
			interior_s1 <= interior;
			last_s1 <= due && last;
		end
	end

	// shift the column down the line store; forward a same-column write
	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_q[col_s1] <= {rd_s1[0], bit_s1};
		end
		if (accept) begin
			if (store_wr && col_s1 == col_q) begin
				rd_s1 <= {rd_s1[0], bit_s1};
			end else begin
				rd_s1 <= store_q[col_q];
			end
		end
	end

	assign cls_valid = valid_s1;
	assign cls_data = '{
		vec: {rd_s1[1], rd_s1[0], bit_s1},
		due: due_s1,
		interior: interior_s1,
		last: last_s1
	};
endmodule

// ===== rtl/ge3_queue.sv =====
module ge3_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input ge3_pkg::ge3_cls_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output ge3_pkg::ge3_cls_t pop_data
);
	import ge3_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	ge3_cls_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != NW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end
endmodule

// ===== rtl/ge3_back.sv =====
module ge3_back (
	input logic clk,
	input logic arst_n,
	input logic restart,
	input logic pop_valid,
	output logic pop_ready,
	input ge3_pkg::ge3_cls_t pop_data,
	ge3_chan_if.source nav
);
	import ge3_pkg::*;

	logic [8:0] window_q;
	logic [8:0] win_nxt;
	logic out_valid_q;
	logic pop;

	assign pop_ready = !out_valid_q || nav.ready;
	assign pop = pop_valid && pop_ready;
	assign win_nxt = {window_q[5:0], pop_data.vec};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (restart) begin
			window_q <= '0;
		end else if (pop) begin
			// drop the window after the final tile of a grid
			window_q <= pop_data.last ? '0 : win_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop && pop_data.due;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_data.due) begin
			nav.data <= '{
				nav_walkable: pop_data.interior && (win_nxt == '1),
				last_tile: pop_data.last
			};
		end
	end

	assign nav.valid = out_valid_q;
endmodule

// ===== rtl/grid_erosion_3x3.sv =====
// 3x3 eight-neighbor erosion of a raster tile grid: a result tile is walkable only when the
// tile and all eight neighbors are walkable, and tiles outside the grid count as wall, so the
// grid border is always wall. The tiles port takes one beat per clock while the queue has
// room; the result for a tile comes out with the beat that arrives grid_columns+1 beats
// after it and reaches nav through the line-store read register, queue and output register.
// Send grid_columns+1 padding beats after the last tile to flush the final results; the result
// for the last tile of the grid carries last_tile and the following beat starts a new grid.
// Writing either size register restarts the grid; write only while the block is idle. Sizes
// are clamped to 3..MAX_COLUMNS and 3..MAX_ROWS. The two line stores share one MAX_COLUMNS x 2
// memory with one read and one write per beat; it is not cleared after reset, since entries
// from before the first write of a grid only reach border tiles, which are wall anyway.
module grid_erosion_3x3 #(
	parameter int MAX_COLUMNS = ge3_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS = ge3_pkg::DEF_MAX_ROWS
) (
	input logic clk,
	input logic arst_n,
	ge3_chan_if.sink tiles,
	ge3_chan_if.source nav,
	ge3_chan_if.sink cfg
);
	import ge3_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic restart;

	logic cls_valid;
	logic cls_ready;
	ge3_cls_t cls_data;
	logic pop_valid;
	logic pop_ready;
	ge3_cls_t pop_data;

	assign cfg.ready = 1'b1;
	assign restart = cfg.valid
		&& (cfg.data.index inside {REG_GRID_COLUMNS, REG_GRID_ROWS});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_SIZE_RESET;
			rows_q <= CFG_SIZE_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_GRID_COLUMNS: cols_q <= cfg.data.value;
				REG_GRID_ROWS: rows_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_q < CFG_SIZE_MIN) begin
			col_last = CW'(2);
		end else if (int'(cols_q) > MAX_COLUMNS) begin
			col_last = CW'(MAX_COLUMNS - 1);
		end else begin
			col_last = CW'(cols_q - CFG_W'(1));
		end
		if (rows_q < CFG_SIZE_MIN) begin
			row_last = RW'(2);
		end else if (int'(rows_q) > MAX_ROWS) begin
			row_last = RW'(MAX_ROWS - 1);
		end else begin
			row_last = RW'(rows_q - CFG_W'(1));
		end
	end

	ge3_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.col_last(col_last),
		.row_last(row_last),
		.restart(restart),
		.tiles(tiles),
		.cls_valid(cls_valid),
		.cls_ready(cls_ready),
		.cls_data(cls_data)
	);

	ge3_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(cls_valid),
		.push_ready(cls_ready),
		.push_data(cls_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	ge3_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.nav(nav)
	);

	// the input only stalls when the front stage is full and the queue refuses it
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!tiles.ready |-> (cls_valid && !cls_ready))
		else $error("tiles stalled without a full front stage and queue");

	// the final tile is a corner, so it is always wall
	a_last_is_wall: assert property (@(posedge clk) disable iff (!arst_n)
		(nav.valid && nav.data.last_tile) |-> !nav.data.nav_walkable)
		else $error("last tile reported walkable");

	// a new result only appears after a beat left the queue
	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(nav.valid) |-> $past(pop_valid && pop_ready))
		else $error("result appeared without a queue pop");
endmodule

// ===== bench/grid_erosion_3x3_test.sv =====
`timescale 1ns / 100ps

module grid_erosion_3x3_test;
	import ge3_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_TILES = 850;

	logic clk;
	logic arst_n;

	ge3_chan_if #(.T(ge3_in_t)) tiles_if ();
	ge3_chan_if #(.T(ge3_out_t)) nav_if ();
	ge3_chan_if #(.T(ge3_cfg_t)) cfg_if ();

	grid_erosion_3x3 i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tiles(tiles_if),
		.nav(nav_if),
		.cfg(cfg_if)
	);

	// erosion state mirrored on the bench side
	bit upper_row [DEF_MAX_COLUMNS];
	bit lower_row [DEF_MAX_COLUMNS];
	logic [8:0] window_cells;
	int unsigned raster_col;
	int unsigned raster_row;
	int unsigned next_tile;
	logic [CFG_W-1:0] cfg_columns;
	logic [CFG_W-1:0] cfg_rows;

	ge3_out_t nav_expected [$];
	int unsigned mismatches;
	int unsigned tiles_sent;
	bit tile_gaps_on;
	bit nav_stalls_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < CFG_SIZE_MIN)
			return CFG_SIZE_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void clear_raster();
		window_cells = '0;
		raster_col = 0;
		raster_row = 0;
		next_tile = 0;
	endfunction

	// shift one tile through the line stores and window; return 1 when a result is due
	function automatic bit predict_nav(input logic walk, input logic pad, output ge3_out_t res);
		int unsigned cols;
		int unsigned rows;
		int unsigned total;
		int unsigned tile;
		int unsigned orow;
		int unsigned ocol;
		logic bit_in;
		logic top;
		logic mid;
		bit due;
		bit interior;
		cols = clamp_size(cfg_columns, DEF_MAX_COLUMNS);
		rows = clamp_size(cfg_rows, DEF_MAX_ROWS);
		total = cols * rows;
		bit_in = pad ? 1'b0 : walk;
		top = 1'b0;
		mid = 1'b0;
		res = '0;
		if (raster_col < DEF_MAX_COLUMNS) begin
			top = upper_row[raster_col];
			mid = lower_row[raster_col];
			upper_row[raster_col] = mid;
			lower_row[raster_col] = bit_in;
		end
		window_cells = {window_cells[5:0], top, mid, bit_in};
		due = (raster_row > 1) || (raster_row == 1 && raster_col >= 1);
		if (raster_col + 1 >= cols) begin
			raster_col = 0;
			if (raster_row < 'h7FF)
				raster_row++;
		end else begin
			raster_col++;
		end
		if (!due || next_tile >= total)
			return 1'b0;
		tile = next_tile;
		orow = tile / cols;
		ocol = tile % cols;
		interior = orow != 0 && orow + 1 < rows && ocol != 0 && ocol + 1 < cols;
		res.nav_walkable = interior && window_cells == 9'h1FF;
		res.last_tile = (tile + 1 == total);
		if (res.last_tile)
			clear_raster();
		else
			next_tile++;
		return 1'b1;
	endfunction

	task automatic send_tile(input logic walk, input logic pad);
		int unsigned gap;
		ge3_out_t res;
		gap = tile_gaps_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			tiles_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tiles_if.valid <= 1'b1;
		tiles_if.data <= ge3_in_t'{tile_walkable: walk, padding: pad};
		@(posedge clk);
		while (!tiles_if.ready)
			@(posedge clk);
		tiles_sent++;
		if (predict_nav(walk, pad, res))
			nav_expected.insert(nav_expected.size(), res);
	endtask

	// hold the tile stream until every expected result has come out
	task automatic wait_results_done();
		tiles_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (nav_expected.size() != 0);
	endtask

	task automatic write_size_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= ge3_cfg_t'{index: index, value: value};
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		if (index == REG_GRID_COLUMNS) begin
			cfg_columns = value;
			clear_raster();
		end else if (index == REG_GRID_ROWS) begin
			cfg_rows = value;
			clear_raster();
		end
	endtask

	// one full grid followed by its flush beats; pause_at < 0 means no mid-grid drain
	task automatic send_grid(input int unsigned cols, input int unsigned rows,
			input int unsigned walk_pct, input bit noisy, input int pause_at);
		int unsigned i;
		logic pad;
		for (i = 0; i < cols * rows; i++) begin
			if (i == pause_at)
				wait_results_done();
			pad = noisy && ($urandom_range(0, 99) < 4);
			send_tile($urandom_range(0, 99) < walk_pct, pad);
		end
		for (i = 0; i <= cols; i++)
			send_tile(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
	endtask

	function automatic logic [CFG_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return CFG_W'($urandom_range(0, 2));
		if (r == 1)
			return CFG_W'($urandom_range(9, 24));
		return CFG_W'($urandom_range(3, 8));
	endfunction

	task automatic test_reset_sizes();
		send_tile(1'b1, 1'b1);
		send_tile(1'b0, 1'b0);
	endtask

	task automatic test_min_grid();
		int unsigned i;
		write_size_reg(REG_GRID_COLUMNS, CFG_W'(3));
		write_size_reg(REG_GRID_ROWS, CFG_W'(3));
		for (i = 0; i < 9; i++)
			send_tile(1'b1, 1'b0);
		// flush with real tiles mixed in
		send_tile(1'b1, 1'b0);
		send_tile(1'b1, 1'b1);
		send_tile(1'b1, 1'b0);
		send_tile(1'b0, 1'b1);
	endtask

	task automatic test_clamped_low();
		int unsigned i;
		write_size_reg(REG_GRID_COLUMNS, CFG_W'(0));
		write_size_reg(REG_GRID_ROWS, CFG_W'(2));
		write_size_reg(REG_SPARE_HI, CFG_W'(5));
		// padding on the center tile kills the only interior result
		for (i = 0; i < 9; i++)
			send_tile(1'b1, i == 4);
		for (i = 0; i < 4; i++)
			send_tile(1'b0, 1'b1);
	endtask

	task automatic test_random_grids();
		int unsigned start_count;
		int unsigned kind;
		int unsigned cols_v;
		int unsigned rows_v;
		int pause_at;
		bit first;
		start_count = tiles_sent;
		first = 1'b1;
		while (tiles_sent - start_count < RANDOM_TILES) begin
			tile_gaps_on = ($urandom_range(0, 3) != 0);
			nav_stalls_on = ($urandom_range(0, 3) != 0);
			if (first || $urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 3))
					0: write_size_reg(REG_GRID_COLUMNS, pick_size());
					1: write_size_reg(REG_GRID_ROWS, pick_size());
					default: begin
						write_size_reg(REG_GRID_COLUMNS, pick_size());
						write_size_reg(REG_GRID_ROWS, pick_size());
					end
				endcase
				if ($urandom_range(0, 7) == 0)
					write_size_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
							CFG_W'($urandom_range(0, 2047)));
			end
			cols_v = clamp_size(cfg_columns, DEF_MAX_COLUMNS);
			rows_v = clamp_size(cfg_rows, DEF_MAX_ROWS);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				pause_at = (first || $urandom_range(0, 5) == 0) ?
						$urandom_range(0, cols_v * rows_v - 1) : -1;
				send_grid(cols_v, rows_v, $urandom_range(70, 100), kind == 0, pause_at);
			end else if (kind < 9) begin
				// broken grid: stop somewhere before or inside the flush
				repeat ($urandom_range(1, cols_v * rows_v + cols_v))
					send_tile(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
			end else begin
				repeat ($urandom_range(1, 20))
					send_tile(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			first = 1'b0;
		end
	endtask

	// oversized column count clamps to the line store depth, so no result is due yet
	task automatic test_wide_grid();
		int unsigned i;
		tile_gaps_on = 1'b1;
		nav_stalls_on = 1'b1;
		write_size_reg(REG_GRID_COLUMNS, CFG_W'(2047));
		write_size_reg(REG_GRID_ROWS, CFG_W'(3));
		for (i = 0; i < 48; i++)
			send_tile($urandom_range(0, 99) < 97, 1'b0);
	endtask

	// oversized row count clamps high, so a long run of rows never reaches the last tile
	task automatic test_tall_grid();
		int unsigned i;
		tile_gaps_on = 1'b1;
		nav_stalls_on = 1'b1;
		write_size_reg(REG_GRID_COLUMNS, CFG_W'(2));
		write_size_reg(REG_GRID_ROWS, CFG_W'(2047));
		for (i = 0; i < 90; i++)
			send_tile($urandom_range(0, 99) < 97, 1'b0);
	endtask

	initial begin
		tiles_if.valid <= 1'b0;
		tiles_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		arst_n <= 1'b0;
		cfg_columns = CFG_SIZE_RESET;
		cfg_rows = CFG_SIZE_RESET;
		clear_raster();
		mismatches = 0;
		tiles_sent = 0;
		tile_gaps_on = 1'b1;
		nav_stalls_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_min_grid();
		test_clamped_low();
		test_random_grids();
		test_wide_grid();
		test_tall_grid();

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && nav_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// result side: random stall per beat, compare against the oldest expectation
	initial begin
		int unsigned stall;
		ge3_out_t want;
		ge3_out_t got;
		nav_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = nav_stalls_on ? $urandom_range(0, 9) : 0;
			if (stall != 0) begin
				nav_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			nav_if.ready <= 1'b1;
			@(posedge clk);
			while (!nav_if.valid)
				@(posedge clk);
			got = nav_if.data;
			if (nav_expected.size() == 0) begin
				$error("nav beat with no result expected: nav_walkable %0b last_tile %0b",
						got.nav_walkable, got.last_tile);
				mismatches++;
			end else begin
				want = nav_expected.pop_front();
				if (got.nav_walkable !== want.nav_walkable) begin
					$error("nav_walkable: expected %0b, got %0b", want.nav_walkable,
							got.nav_walkable);
					mismatches++;
				end
				if (got.last_tile !== want.last_tile) begin
					$error("last_tile: expected %0b, got %0b", want.last_tile, got.last_tile);
					mismatches++;
				end
			end
		end
	end

endmodule

// ===== sim.f =====
rtl/ge3_pkg.sv
rtl/ge3_chan_if.sv
rtl/ge3_front.sv
rtl/ge3_queue.sv
rtl/ge3_back.sv
rtl/grid_erosion_3x3.sv
bench/grid_erosion_3x3_test.sv
